>>> sv/hog_pkg.sv
// Shared types and constants for the gradient orientation histogram block.
// Holds request and result payload structs and the controller/datapath command and status bundles.
// No dependencies.
`default_nettype none
package hog_pkg;

  localparam int NUM_BINS   = 8;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int PIX_W      = 8;
  localparam int ACC_W      = 21;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int RAD_W      = SQ_W + 1 + 8;
  localparam int ROOT_W     = RAD_W + 1;
  localparam int MAG_W      = 13;
  localparam int CELL_SIDE  = 16;

  typedef struct packed {
    logic [PIX_W-1:0] left_pixel;
    logic [PIX_W-1:0] right_pixel;
    logic [PIX_W-1:0] above_pixel;
    logic [PIX_W-1:0] below_pixel;
    logic             cell_end;
  } hog_in_t;

  typedef struct packed {
    logic [ACC_W-1:0] bin_0_sum;
    logic [ACC_W-1:0] bin_1_sum;
    logic [ACC_W-1:0] bin_2_sum;
    logic [ACC_W-1:0] bin_3_sum;
    logic [ACC_W-1:0] bin_4_sum;
    logic [ACC_W-1:0] bin_5_sum;
    logic [ACC_W-1:0] bin_6_sum;
    logic [ACC_W-1:0] bin_7_sum;
  } hog_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic commit;
  } hog_cmd_t;

  typedef struct packed {
    logic sqrt_last;
    logic last;
  } hog_sts_t;

endpackage
`default_nettype wire

>>> sv/hog_dp.sv
// Datapath: gradients, octant, iterative square root and bin accumulators.
// Driven by hog_ctrl through hog_cmd_t; depends on hog_pkg.
`default_nettype none
module hog_dp (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire hog_pkg::hog_in_t  in_data,
  input  wire hog_pkg::hog_cmd_t cmd,
  output hog_pkg::hog_sts_t      sts,
  output hog_pkg::hog_out_t      out_data
);
  import hog_pkg::*;

  logic signed [PIX_W:0] gx, gy;
  logic [PIX_W-1:0]      ax, ay;
  logic [BIN_W-1:0]      bin_nxt;

  logic [BIN_W-1:0]  bin_r;
  logic              last_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r;
  logic [RAD_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RAD_W-1:0]  bit_r;

  logic [ROOT_W-1:0] trial;
  logic              take;
  logic [MAG_W-1:0]  mag;
  logic [ACC_W:0]    add_sum;
  logic [ACC_W-1:0]  sat_sum;
  logic [ACC_W-1:0]  acc_r [NUM_BINS];
  logic [ACC_W-1:0]  acc_nxt [NUM_BINS];
  hog_out_t          out_r;

  function automatic logic [BIN_W-1:0] octant(
    input logic signed [PIX_W:0] dx,
    input logic signed [PIX_W:0] dy,
    input logic [PIX_W-1:0]      mx,
    input logic [PIX_W-1:0]      my
  );
    logic [BIN_W-1:0] b;
    if (dy == '0) begin
      b = dx[PIX_W] ? BIN_W'(4) : BIN_W'(0);
    end else if (!dy[PIX_W]) begin
      if (!dx[PIX_W] && dx != '0) b = (my < mx) ? BIN_W'(0) : BIN_W'(1);
      else if (dx == '0)          b = BIN_W'(2);
      else                        b = (my > mx) ? BIN_W'(2) : BIN_W'(3);
    end else begin
      if (dx[PIX_W])              b = (my < mx) ? BIN_W'(4) : BIN_W'(5);
      else if (dx == '0)          b = BIN_W'(6);
      else                        b = (my > mx) ? BIN_W'(6) : BIN_W'(7);
    end
    return b;
  endfunction

  always_comb begin
    gx = $signed({1'b0, in_data.right_pixel}) - $signed({1'b0, in_data.left_pixel});
    gy = $signed({1'b0, in_data.below_pixel}) - $signed({1'b0, in_data.above_pixel});
    ax = gx[PIX_W] ? PIX_W'(-gx) : gx[PIX_W-1:0];
    ay = gy[PIX_W] ? PIX_W'(-gy) : gy[PIX_W-1:0];
    bin_nxt = octant(gx, gy, ax, ay);
  end

  always_comb begin
    trial   = root_r + {1'b0, bit_r};
    take    = {1'b0, rem_r} >= trial;
    mag     = root_r[MAG_W-1:0] + MAG_W'({1'b0, rem_r} > root_r);
    add_sum = {1'b0, acc_r[bin_r]} + (ACC_W+1)'(mag);
    sat_sum = add_sum[ACC_W] ? {ACC_W{1'b1}} : add_sum[ACC_W-1:0];
    for (int k = 0; k < NUM_BINS; k++) begin
      acc_nxt[k] = (BIN_W'(k) == bin_r) ? sat_sum : acc_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r  <= bin_nxt;
      last_r <= in_data.cell_end;
      sq_x_r <= ax * ax;
      sq_y_r <= ay * ay;
    end
    if (cmd.prep) begin
      rem_r  <= {({1'b0, sq_x_r} + {1'b0, sq_y_r}), 8'd0};
      root_r <= '0;
      bit_r  <= RAD_W'(1) << (RAD_W - 1);
    end else if (cmd.step) begin
      if (take) begin
        rem_r  <= RAD_W'({1'b0, rem_r} - trial);
        root_r <= (root_r >> 1) + {1'b0, bit_r};
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.commit && last_r) begin
      out_r <= {acc_nxt[0], acc_nxt[1], acc_nxt[2], acc_nxt[3],
                acc_nxt[4], acc_nxt[5], acc_nxt[6], acc_nxt[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_BINS; k++) acc_r[k] <= '0;
    end else if (cmd.commit) begin
      for (int k = 0; k < NUM_BINS; k++) acc_r[k] <= last_r ? '0 : acc_nxt[k];
    end
  end

  assign sts.sqrt_last = (bit_r == RAD_W'(1));
  assign sts.last      = last_r;
  assign out_data      = out_r;

endmodule
`default_nettype wire

>>> sv/hog_ctrl.sv
// Controller: sequences load, root iterations and accumulation per request.
// Owns the input stall and the result valid; depends on hog_pkg.
`default_nettype none
module hog_ctrl (
  input  wire                    logic clk,
  input  wire                    logic rst_n,
  input  wire                    logic in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire                    logic out_stall,
  input  wire hog_pkg::hog_sts_t       sts,
  output hog_pkg::hog_cmd_t            cmd
);
  import hog_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;
  localparam logic [1:0] S_ACC  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       blocked;

  always_comb begin
    blocked       = sts.last && out_valid_r && out_stall;
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.step = 1'b1;
        if (sts.sqrt_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!blocked) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
          if (sts.last) out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_PREP))
    else $error("accepted request did not start root preparation");
  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && sts.sqrt_last) |=> (state_r == S_ACC))
    else $error("root finished without accumulate");
  a_rise_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_ACC && $past(sts.last)))
    else $error("result valid rose outside a cell-end commit");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && sts.last) |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

>>> sv/gradient_orientation_histogram_top.sv
// Top level of the gradient orientation histogram block.
// Instantiates hog_ctrl and hog_dp; depends on hog_pkg.
//
// Each pixel request is handled in order: capture it and form the gradients,
// octant and squares; set up the square root; run the bit-serial square root
// of the squared magnitude, scaled by 256, and add the rounded root into the
// bin accumulator. The root iteration sets the rate. On a cell's last pixel
// the eight sums go to an output register that holds them until taken;
// further pixels are accepted meanwhile, and only the next cell end waits
// for that register to drain.
`default_nettype none
module gradient_orientation_histogram_top (
  input  wire                   logic clk,
  input  wire                   logic rst_n,
  input  wire                   logic in_valid,
  output logic                        in_stall,
  input  wire hog_pkg::hog_in_t       in_data,
  output logic                        out_valid,
  input  wire                   logic out_stall,
  output hog_pkg::hog_out_t           out_data
);
  import hog_pkg::*;

  hog_cmd_t cmd;
  hog_sts_t sts;

  hog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hog_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> tb/hog_histogram_scoreboard_pkg.sv
// Scoreboard for the gradient orientation histogram block: predicts each cell's
// eight bin sums from accepted pixel requests and checks the sums that come out.
// Depends on hog_pkg.
package hog_histogram_scoreboard_pkg;
  import hog_pkg::*;

  localparam int unsigned ACC_LIMIT   = (1 << ACC_W) - 1;
  localparam int          MAX_REPORTS = 10;

  typedef logic [NUM_BINS*ACC_W-1:0] hist_flat_t;

  class hog_histogram_scoreboard;
    int unsigned bin_sum [NUM_BINS];
    hog_out_t    histogram_q [$];
    int          failures;

    function new();
      foreach (bin_sum[k]) bin_sum[k] = 0;
      failures = 0;
    endfunction

    static function int unsigned grad_magnitude(int gx, int gy);
      longint unsigned sq;
      longint unsigned root;
      longint unsigned trial;
      sq = longint'(gx * gx + gy * gy) * 256;
      root = 0;
      for (int b = 12; b >= 0; b--) begin
        trial = root | (longint'(1) << b);
        if (trial * trial <= sq) root = trial;
      end
      if (sq - root * root > root) root++;
      return int'(root);
    endfunction

    static function int unsigned grad_octant(int gx, int gy);
      int ax;
      int ay;
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      if (gy == 0) return gx < 0 ? 4 : 0;
      if (gy > 0) begin
        if (gx > 0) return ay < ax ? 0 : 1;
        if (gx == 0) return 2;
        return ay > ax ? 2 : 3;
      end
      if (gx < 0) return ay < ax ? 4 : 5;
      if (gx == 0) return 6;
      return ay > ax ? 6 : 7;
    endfunction

    static function logic [ACC_W-1:0] bin_of(hog_out_t h, int k);
      hist_flat_t flat;
      flat = h;
      return flat[(NUM_BINS-1-k)*ACC_W +: ACC_W];
    endfunction

    function void note_pixel(hog_in_t px);
      int          l, r, a, d, gx, gy;
      int unsigned b, total;
      hist_flat_t  flat;
      l = int'(px.left_pixel);
      r = int'(px.right_pixel);
      a = int'(px.above_pixel);
      d = int'(px.below_pixel);
      gx = r - l;
      gy = d - a;
      b = grad_octant(gx, gy);
      total = bin_sum[b] + grad_magnitude(gx, gy);
      bin_sum[b] = total > ACC_LIMIT ? ACC_LIMIT : total;
      if (px.cell_end) begin
        for (int k = 0; k < NUM_BINS; k++) begin
          flat[(NUM_BINS-1-k)*ACC_W +: ACC_W] = ACC_W'(bin_sum[k]);
          bin_sum[k] = 0;
        end
        histogram_q.push_back(hog_out_t'(flat));
      end
    endfunction

    function void check_histogram(hog_out_t got);
      hog_out_t want;
      if (histogram_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $display("unexpected histogram %h", got);
        return;
      end
      want = histogram_q.pop_front();
      for (int k = 0; k < NUM_BINS; k++) begin
        if (bin_of(got, k) !== bin_of(want, k)) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("bin %0d sum mismatch: expected %0d, got %0d",
                     k, bin_of(want, k), bin_of(got, k));
        end
      end
    endfunction
  endclass
endpackage

>>> tb/testbench.sv
// Testbench for gradient_orientation_histogram_top: drives pixel requests with
// random gaps and stalls, and checks cell histograms against the scoreboard.
// Depends on hog_pkg and hog_histogram_scoreboard_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hog_pkg::*;
  import hog_histogram_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 48;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hog_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  hog_out_t out_data;

  hog_histogram_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int cycle_count;

  int directed_grad [19][2] = '{
    '{0, 0}, '{255, 0}, '{-255, 0}, '{0, 255}, '{0, -255},
    '{100, 100}, '{-100, 100}, '{-100, -100}, '{100, -100},
    '{255, 255}, '{-255, -255},
    '{10, 3}, '{3, 10}, '{-3, 10}, '{-10, 3},
    '{-10, -3}, '{-3, -10}, '{3, -10}, '{10, -3}
  };

  gradient_orientation_histogram_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_histogram(out_data);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic hog_in_t make_pixel(int gx, int gy, bit last);
    hog_in_t px;
    int      base;
    base = $urandom_range(255 - (gx < 0 ? -gx : gx));
    if (gx >= 0) begin
      px.left_pixel  = PIX_W'(base);
      px.right_pixel = PIX_W'(base + gx);
    end else begin
      px.right_pixel = PIX_W'(base);
      px.left_pixel  = PIX_W'(base - gx);
    end
    base = $urandom_range(255 - (gy < 0 ? -gy : gy));
    if (gy >= 0) begin
      px.above_pixel = PIX_W'(base);
      px.below_pixel = PIX_W'(base + gy);
    end else begin
      px.below_pixel = PIX_W'(base);
      px.above_pixel = PIX_W'(base - gy);
    end
    px.cell_end = last;
    return px;
  endfunction

  function automatic int rand_sign(int m);
    return $urandom_range(1) ? m : -m;
  endfunction

  function automatic hog_in_t random_pixel(bit last);
    hog_in_t px;
    int      kind;
    int      m;
    kind = $urandom_range(9);
    m = $urandom_range(255);
    if (kind == 6) return make_pixel(rand_sign(m), rand_sign(m), last);
    if (kind == 7) return $urandom_range(1) ? make_pixel(rand_sign(m), 0, last)
                                            : make_pixel(0, rand_sign(m), last);
    if (kind == 8) return make_pixel(int'($urandom_range(4)) - 2,
                                     int'($urandom_range(4)) - 2, last);
    if (kind == 9) return make_pixel(rand_sign(255), rand_sign(255), last);
    px = hog_in_t'({$urandom, 1'b0});
    px.cell_end = last;
    return px;
  endfunction

  task automatic send_pixel(input hog_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_cells(input int count, input int max_len);
    int left_in_cell;
    left_in_cell = 0;
    for (int i = 0; i < count; i++) begin
      if (left_in_cell == 0) left_in_cell = $urandom_range(1, max_len);
      left_in_cell--;
      send_pixel(random_pixel(left_in_cell == 0 || i == count - 1));
    end
  endtask

  task automatic send_saturating_cell(input int count);
    for (int i = 0; i < count; i++) send_pixel(make_pixel(255, 255, i == count - 1));
  endtask

  initial begin
    sb = new();
    send_idle_pct  = 10;
    recv_stall_pct = 77;
    hold_req       = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_grad[i])
      send_pixel(make_pixel(directed_grad[i][0], directed_grad[i][1], 1'b1));
    send_pixel(make_pixel(0, 0, 1'b0));
    send_pixel(make_pixel(-255, -255, 1'b0));
    send_pixel(make_pixel(255, -1, 1'b0));
    send_pixel(make_pixel(-1, 255, 1'b1));
    send_random_cells(560, 24);

    send_idle_pct  = 77;
    recv_stall_pct = 10;
    send_saturating_cell(400);
    send_random_cells(420, 24);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_random_cells(100, 2);
    send_random_cells(450, 24);

    in_valid <= 1'b0;
    while (sb.histogram_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.histogram_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
